// ===== src/psd_pkg.sv =====
// psd_pkg: shared types and constants for the ps/2 scan-code event decoder
// scan-code set 2 prefix and modifier key codes, phase enum, result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // prefix bytes
  localparam logic [7:0] CODE_EXT   = 8'hE0;
  localparam logic [7:0] CODE_BREAK = 8'hF0;

  // modifier keys
  localparam logic [7:0] KEY_ALT    = 8'h11;
  localparam logic [7:0] KEY_LSHIFT = 8'h12;
  localparam logic [7:0] KEY_RSHIFT = 8'h59;
  localparam logic [7:0] KEY_CTRL   = 8'h14;
  localparam logic [7:0] KEY_CAPS   = 8'h58;

  // bit positions in the modifier field
  localparam int MOD_SHIFT = 0;
  localparam int MOD_ALT   = 1;
  localparam int MOD_CTRL  = 2;
  localparam int MOD_CAPS  = 3;

  localparam int MOD_W      = 4;
  localparam int CODE_W     = 8;
  localparam int RES_BITS   = 1 + CODE_W + MOD_W;
  localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

  // prefix tracking
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EXT  = 2'd1,
    PH_REL  = 2'd2
  } phase_t;

  // one decoded key action
  typedef struct packed {
    logic [MOD_W-1:0]  modifiers;
    logic [CODE_W-1:0] key_code;
    logic              is_release;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ps2_scancode_event_decoder.sv =====
// ps2_scancode_event_decoder: top level of the ps/2 set-2 scan-code decoder
// input byte register, decode stage and result register; depends on psd_pkg,
// psd_decode and psd_out_reg
//
// usage:
//   s_axis carries one raw scan-code byte per beat (tdata[7:0]).
//   m_axis carries one key action per beat for every completed press or
//   release of a non-modifier key; prefix bytes and modifier keys give none.
//   a byte is taken into the input register, decoded against the prefix
//   phase and modifier state, and the result lands in the output register.
//   the final byte of an action is held in the input register, and its result is registered in the output register.
//   throughput: one byte per cycle, set by the single decode stage between
//   the input and result registers; the input side keeps moving while a
//   result waits, as long as the byte held does not need the output slot.
//   when m_axis_tready is low and the output register is full, a byte that
//   completes a key action waits in the input register and s_axis_tready
//   drops; prefix and modifier bytes still drain.
//   reset (rst, synchronous) empties both registers, clears the modifier
//   bits and caps-held flag and returns the prefix phase to idle.
`timescale 1ns / 1ps
`default_nettype none

module ps2_scancode_event_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // scan_code[7:0]
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // is_release[0], key_code[8:1], modifiers[12:9], zero[15:13]
  output logic [psd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import psd_pkg::*;

  logic              in_valid;
  logic [CODE_W-1:0] in_code;
  logic              emit;
  logic              out_free;
  logic              advance;
  result_t           result;

  // the held byte moves on unless it needs a full output slot
  assign advance       = in_valid && (!emit || out_free);
  assign s_axis_tready = !in_valid || advance;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_code <= s_axis_tdata;
    end
  end

  // decode stage
  psd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .code   (in_code),
    .emit   (emit),
    .result (result)
  );

  // result register
  psd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && emit),
    .result        (result),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a result is only loaded when the output slot has room
  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  // a byte that yields no result never blocks the input
  a_no_result_drains: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !emit) |-> s_axis_tready)
    else $error("non-result byte stalled the input");

  // modifier keys never appear as results
  a_no_modifier_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[8:1] != KEY_ALT && m_axis_tdata[8:1] != KEY_LSHIFT &&
                       m_axis_tdata[8:1] != KEY_RSHIFT && m_axis_tdata[8:1] != KEY_CTRL &&
                       m_axis_tdata[8:1] != KEY_CAPS))
    else $error("modifier key emitted as a result");
`endif

endmodule

`default_nettype wire

// ===== src/psd_decode.sv =====
// psd_decode: prefix tracking, modifier state and key action decode
// holds phase, modifier bits and caps-held flag; depends on psd_pkg
`timescale 1ns / 1ps
`default_nettype none

module psd_decode (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic [psd_pkg::CODE_W-1:0] code,
  output logic                           emit,
  output psd_pkg::result_t               result
);
  import psd_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [MOD_W-1:0]  mods;
  logic [MOD_W-1:0]  mods_next;
  logic              caps_held;
  logic              caps_held_next;
  logic              release_flag;
  logic              complete;

  // prefix phase decode
  always_comb begin
    phase_next   = phase;
    release_flag = 1'b0;
    complete     = 1'b0;
    unique case (phase)
      PH_REL: begin
        release_flag = 1'b1;
        complete     = 1'b1;
      end
      PH_EXT: begin
        if (code == CODE_BREAK) begin
          phase_next = PH_REL;
        end else begin
          complete = 1'b1;
        end
      end
      default: begin
        // unused phase code behaves as idle
        if (code == CODE_EXT) begin
          phase_next = PH_EXT;
        end else if (code == CODE_BREAK) begin
          phase_next = PH_REL;
        end else begin
          complete = 1'b1;
        end
      end
    endcase
    if (complete) begin
      phase_next = PH_IDLE;
    end
  end

  // modifier update and result
  always_comb begin
    mods_next      = mods;
    caps_held_next = caps_held;
    emit           = 1'b0;
    if (complete) begin
      priority if (code == KEY_ALT) begin
        mods_next[MOD_ALT] = !release_flag;
      end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
        mods_next[MOD_SHIFT] = !release_flag;
      end else if (code == KEY_CTRL) begin
        mods_next[MOD_CTRL] = !release_flag;
      end else if (code == KEY_CAPS) begin
        if (release_flag) begin
          caps_held_next = 1'b0;
        end else if (!caps_held) begin
          mods_next[MOD_CAPS] = !mods[MOD_CAPS];
          caps_held_next      = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end
    end
    result.is_release = release_flag;
    result.key_code   = code;
    result.modifiers  = mods_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      mods      <= '0;
      caps_held <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      mods      <= mods_next;
      caps_held <= caps_held_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/psd_out_reg.sv =====
// psd_out_reg: result register in front of the master-side stream
// holds one decoded result until the downstream beat completes; depends on psd_pkg
`timescale 1ns / 1ps
`default_nettype none

module psd_out_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire psd_pkg::result_t             result,
  output logic                              free,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [psd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import psd_pkg::*;

  logic    full;
  result_t held;

  // room for a new result this cycle
  assign free = !full || m_axis_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_BITS){1'b0}}, held};

endmodule

`default_nettype wire

// ===== tb/sv/tb_ps2_scancode_event_decoder.sv =====
// tb_ps2_scancode_event_decoder: self-checking bench for the ps/2 scan-code decoder
// drives scan-code beats, predicts key actions from its own prefix/modifier tracker
// and checks every result beat; depends on psd_pkg and ps2_scancode_event_decoder
`timescale 1ns / 1ps

module tb_ps2_scancode_event_decoder;
  import psd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;   // scan_code[7:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // is_release[0], key_code[8:1], modifiers[12:9], zero[15:13]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  ps2_scancode_event_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // keyboard state as the bench sees it
  phase_t     kb_phase = PH_IDLE;
  logic [3:0] kb_mods = 4'h0;
  logic       kb_caps_held = 1'b0;

  result_t    pending_actions[$];
  int         err_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         rx_hold_cycles = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one line per mismatch, counted
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // prefix tracking and modifier update for one byte; returns 1 when a key action completes
  function automatic bit decode_scan_code(input logic [7:0] code, output result_t act);
    logic       rel;
    logic [3:0] mask;
    act  = '0;
    rel  = 1'b0;
    mask = '0;
    case (kb_phase)
      PH_REL: rel = 1'b1;
      PH_EXT: begin
        if (code == CODE_BREAK) begin
          kb_phase = PH_REL;
          return 1'b0;
        end
      end
      // idle, and the unused phase behaves as idle
      default: begin
        if (code == CODE_EXT) begin
          kb_phase = PH_EXT;
          return 1'b0;
        end
        if (code == CODE_BREAK) begin
          kb_phase = PH_REL;
          return 1'b0;
        end
      end
    endcase
    kb_phase = PH_IDLE;

    // held modifiers
    if (code == KEY_ALT) mask[MOD_ALT] = 1'b1;
    else if (code == KEY_LSHIFT || code == KEY_RSHIFT) mask[MOD_SHIFT] = 1'b1;
    else if (code == KEY_CTRL) mask[MOD_CTRL] = 1'b1;
    if (mask != '0) begin
      kb_mods = rel ? (kb_mods & ~mask) : (kb_mods | mask);
      return 1'b0;
    end

    // caps lock toggles once per hold
    if (code == KEY_CAPS) begin
      if (rel) begin
        kb_caps_held = 1'b0;
      end else if (!kb_caps_held) begin
        kb_mods[MOD_CAPS] = ~kb_mods[MOD_CAPS];
        kb_caps_held      = 1'b1;
      end
      return 1'b0;
    end

    act.is_release = rel;
    act.key_code   = code;
    act.modifiers  = kb_mods;
    return 1'b1;
  endfunction

  // send one scan-code beat; called and returning at a rising edge
  task automatic send_scan_code(input logic [7:0] code);
    int      gap;
    result_t act;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk); while (!s_axis_tready);
    if (decode_scan_code(code, act)) pending_actions.push_back(act);
  endtask

  // stop offering beats and wait for every expected action, then let the pipeline drain
  task automatic wait_for_actions();
    s_axis_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // compare one result beat with the oldest expected action
  task automatic check_action(input logic [OUT_DATA_W-1:0] beat);
    result_t got;
    result_t want;
    got = result_t'(beat[RES_BITS-1:0]);
    if (beat[OUT_DATA_W-1:RES_BITS] != '0)
      report_mismatch($sformatf("padding bits not zero in beat %h", beat));
    if (pending_actions.size() == 0) begin
      report_mismatch($sformatf("action with none expected: %h", beat));
    end else begin
      want = pending_actions.pop_front();
      if (got.is_release !== want.is_release)
        report_mismatch($sformatf("is_release %b, expected %b", got.is_release,
                                  want.is_release));
      if (got.key_code !== want.key_code)
        report_mismatch($sformatf("key_code %h, expected %h", got.key_code,
                                  want.key_code));
      if (got.modifiers !== want.modifiers)
        report_mismatch($sformatf("modifiers %b, expected %b", got.modifiers,
                                  want.modifiers));
    end
  endtask

  // result side: check each beat and pace tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_action(m_axis_tdata);
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // extremes, prefix forms, modifiers, caps hold and prefix bytes as keys
  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF,
            CODE_EXT, 8'h75,
            CODE_BREAK, 8'h1C,
            CODE_EXT, CODE_BREAK, 8'h75,
            KEY_RSHIFT, KEY_ALT, CODE_EXT, KEY_CTRL,
            KEY_CAPS, KEY_CAPS, 8'h1C,
            CODE_BREAK, KEY_CAPS,
            CODE_EXT, CODE_EXT,
            CODE_BREAK, CODE_BREAK,
            CODE_BREAK, CODE_EXT,
            CODE_EXT, CODE_BREAK, KEY_LSHIFT};
    foreach (seq[i]) send_scan_code(seq[i]);
    wait_for_actions();
  endtask

  // pick a key, biased towards modifiers so their state keeps changing
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
    if (r < 14) return KEY_ALT;
    if (r < 20) return KEY_CTRL;
    if (r < 28) return KEY_CAPS;
    if (r < 31) return $urandom_range(1) ? CODE_EXT : CODE_BREAK;
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed press/release sequences, some stray bytes
  task automatic send_random_actions(input int count);
    int         sent;
    logic [7:0] key;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 10) begin
        send_scan_code(8'($urandom_range(255)));
        sent++;
      end else begin
        key = pick_key();
        case ($urandom_range(3))
          0: begin
            send_scan_code(key);
            sent += 1;
          end
          1: begin
            send_scan_code(CODE_EXT);
            send_scan_code(key);
            sent += 2;
          end
          2: begin
            send_scan_code(CODE_BREAK);
            send_scan_code(key);
            sent += 2;
          end
          default: begin
            send_scan_code(CODE_EXT);
            send_scan_code(CODE_BREAK);
            send_scan_code(key);
            sent += 3;
          end
        endcase
      end
    end
    wait_for_actions();
  endtask

  // random traffic under each idling pattern
  task automatic test_random_idling();
    tx_idle_pct = 35;
    rx_idle_pct = 56;
    send_random_actions(170);
    tx_idle_pct = 56;
    rx_idle_pct = 35;
    send_random_actions(170);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_actions(170);
  endtask

  // result side held off long enough to stall the input, then a full drain mid-stream
  task automatic test_backpressure();
    int i;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 80;
    for (i = 0; i < 40; i++) send_scan_code(8'($urandom_range(255)));
    wait_for_actions();
    for (i = 0; i < 10; i++) send_scan_code(pick_key());
    wait_for_actions();
    for (i = 0; i < 10; i++) send_scan_code(8'($urandom_range(255)));
    wait_for_actions();
  endtask

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_idling();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ps2_scancode_event_decoder.f =====
src/psd_pkg.sv
src/psd_decode.sv
src/psd_out_reg.sv
src/ps2_scancode_event_decoder.sv
tb/sv/tb_ps2_scancode_event_decoder.sv
